// ===== rtl/core/centered_window_average_core_assert.svh =====
// ----------------------------------------------------------------------------
// Centered window average: assertion macros
// Shared property forms for the checker; clk and rst come from the user scope.
// ----------------------------------------------------------------------------
`ifndef CENTERED_WINDOW_AVERAGE_CORE_ASSERT_SVH
`define CENTERED_WINDOW_AVERAGE_CORE_ASSERT_SVH

// same-cycle implication
`define CWA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CWA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cwa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered window average: shared package
// Field widths, window limits and register reset value.
// ----------------------------------------------------------------------------
package cwa_pkg;

  localparam int VALUE_W        = 16;
  localparam int CFG_W          = 7;
  localparam int POS_W          = 16;
  localparam int CWA_MAX_WINDOW = 64;
  localparam int WIN_LIMIT      = 64;
  localparam int SUM_W          = VALUE_W + 6;

  localparam logic [CFG_W-1:0] WSIZE_RESET = 7'd11;

endpackage

// ===== rtl/core/cwa_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cwa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/cwa_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered window average: serial divider
// Signed sum over unsigned count, one quotient bit per cycle, truncating.
// ----------------------------------------------------------------------------
module cwa_div
  import cwa_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [SUM_W-1:0]   dividend,
  input  logic        [CFG_W-1:0]   divisor,
  output logic                      done,
  output logic signed [VALUE_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SUM_W + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [CFG_W-1:0] rem;
  logic [SUM_W-1:0] quo;
  logic [CFG_W-1:0] dvsr;
  logic             neg;

  logic [CFG_W:0]   trial;
  logic [CFG_W:0]   diff;
  logic             ge;
  logic [SUM_W-1:0] mag;
  logic [SUM_W-1:0] signed_quo;

  assign mag        = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
  assign trial      = {rem, quo[SUM_W-1]};
  assign ge         = (trial >= {1'b0, dvsr});
  assign diff       = trial - {1'b0, dvsr};
  assign signed_quo = neg ? (~quo + 1'b1) : quo;
  assign quotient   = signed_quo[VALUE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem  <= '0;
      quo  <= mag;
      dvsr <= divisor;
      neg  <= dividend[SUM_W-1];
    end else if (busy) begin
      rem <= ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
      quo <= {quo[SUM_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/core/centered_window_average_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered window average core
// Mean of a clipped centered window over a sequence of Q8.8 values.
//
//   channel  dir  handshake              payload
//   cfg      in   cfg_valid/cfg_ready    window_size
//   in       in   in_valid/in_ready      feature_value, end_of_sequence
//   out      out  out_valid/out_ready    average, position, is_last
//
// An item that releases no result goes through the check state back to idle.
// For each result, every value leaving or entering the window sum is read
// over the one store read port, then the serial divider runs.
// The store needs no clearing pass at reset.
// The store keeps one slot beyond the widest window, so a value leaving
// the sum is still held when the next request lands.
// A stalled result waits in the output register while the next one runs.
// ----------------------------------------------------------------------------
module centered_window_average_core
  import cwa_pkg::*;
#(
  parameter int MAX_WINDOW = CWA_MAX_WINDOW
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic        [CFG_W-1:0]   window_size,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [VALUE_W-1:0] feature_value,
  input  logic                      end_of_sequence,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] average,
  output logic        [POS_W-1:0]   position,
  output logic                      is_last
);

  localparam int DEPTH_I = MAX_WINDOW + 1;
  localparam int AW    = (DEPTH_I > 1) ? $clog2(DEPTH_I) : 1;
  localparam int EW    = AW + CFG_W + 2;
  localparam int CAP_I = (MAX_WINDOW < WIN_LIMIT) ? MAX_WINDOW : WIN_LIMIT;
  localparam logic [CFG_W-1:0] CAP     = CAP_I[CFG_W-1:0];
  localparam logic [EW-1:0]    DEPTH_E = DEPTH_I[EW-1:0];

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_CHECK    = 3'd1;
  localparam logic [2:0] S_DROP     = 3'd2;
  localparam logic [2:0] S_DROP_ACC = 3'd3;
  localparam logic [2:0] S_ADD      = 3'd4;
  localparam logic [2:0] S_ADD_ACC  = 3'd5;
  localparam logic [2:0] S_DIV      = 3'd6;
  localparam logic [2:0] S_OUT      = 3'd7;

  function automatic logic [AW-1:0] mod_sub(input logic [AW-1:0] a,
                                            input logic [CFG_W-1:0] b);
    logic [EW-1:0] d;
    d = {{(EW-AW){1'b0}}, a} - {{(EW-CFG_W){1'b0}}, b};
    if (d[EW-1]) begin
      d = d + DEPTH_E;
    end
    return d[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] mod_add(input logic [AW-1:0] a,
                                            input logic [CFG_W-1:0] b);
    logic [EW-1:0] s;
    s = {{(EW-AW){1'b0}}, a} + {{(EW-CFG_W){1'b0}}, b};
    if (s >= DEPTH_E) begin
      s = s - DEPTH_E;
    end
    return s[AW-1:0];
  endfunction

  logic [2:0]               state;
  logic [CFG_W-1:0]         wsize;
  logic [AW-1:0]            wr_ptr;
  logic [CFG_W-1:0]         pending;
  logic [CFG_W-1:0]         left_have;
  logic [POS_W-1:0]         next_output;
  logic                     last_flag;
  logic [AW-1:0]            win_lo;
  logic [CFG_W-1:0]         win_len;
  logic [AW-1:0]            tgt_lo;
  logic [CFG_W-1:0]         tgt_len;
  logic signed [SUM_W-1:0]  running_sum;

  logic [CFG_W-1:0]         w_eff;
  logic [CFG_W:0]           w_inc;
  logic [CFG_W-1:0]         half_l;
  logic [CFG_W-1:0]         half_r;
  logic [CFG_W-1:0]         left;
  logic [CFG_W-1:0]         pend_dec;
  logic [CFG_W-1:0]         right;
  logic                     emit_due;
  logic [AW-1:0]            center;

  logic                     in_acc;
  logic                     cfg_acc;
  logic                     rd_en;
  logic [AW-1:0]            rd_addr;
  logic [VALUE_W-1:0]       rd_data;
  logic signed [SUM_W-1:0]  rd_ext;
  logic                     div_start;
  logic                     div_done;
  logic signed [VALUE_W-1:0] div_q;

  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_ready = (state == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign cfg_acc   = cfg_valid && cfg_ready;

  assign w_eff  = (wsize == '0) ? CFG_W'(1) : ((wsize > CAP) ? CAP : wsize);
  assign w_inc  = {1'b0, w_eff} + 1'b1;
  assign half_l = w_eff >> 1;
  assign half_r = w_inc[CFG_W:1] - 1'b1;

  assign left     = (left_have < half_l) ? left_have : half_l;
  assign pend_dec = pending - 1'b1;
  assign right    = (last_flag && (pend_dec < half_r)) ? pend_dec : half_r;
  assign emit_due = last_flag ? (pending != '0) : (pending > half_r);
  assign center   = mod_sub(wr_ptr, pending);

  assign rd_en   = (state == S_DROP) || (state == S_ADD);
  assign rd_addr = (state == S_DROP) ? win_lo : mod_add(win_lo, win_len);
  assign rd_ext  = {{(SUM_W-VALUE_W){rd_data[VALUE_W-1]}}, rd_data};

  assign div_start = (state == S_ADD) && (win_len == tgt_len);

  cwa_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (DEPTH_I)
  ) u_store (
    .clk     (clk),
    .wr_en   (in_acc),
    .wr_addr (wr_ptr),
    .wr_data (feature_value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  cwa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (running_sum),
    .divisor  (tgt_len),
    .done     (div_done),
    .quotient (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      wsize       <= WSIZE_RESET;
      wr_ptr      <= '0;
      pending     <= '0;
      left_have   <= '0;
      next_output <= '0;
      last_flag   <= 1'b0;
      win_lo      <= '0;
      win_len     <= '0;
      running_sum <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (cfg_acc) begin
            wsize       <= window_size;
            wr_ptr      <= '0;
            pending     <= '0;
            left_have   <= '0;
            next_output <= '0;
            win_lo      <= '0;
            win_len     <= '0;
            running_sum <= '0;
          end else if (in_acc) begin
            wr_ptr    <= mod_add(wr_ptr, CFG_W'(1));
            pending   <= pending + 1'b1;
            last_flag <= end_of_sequence;
            state     <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (emit_due) begin
            tgt_lo  <= mod_sub(center, left);
            tgt_len <= left + right + 1'b1;
            state   <= S_DROP;
          end else begin
            if (last_flag) begin
              wr_ptr      <= '0;
              pending     <= '0;
              left_have   <= '0;
              next_output <= '0;
              win_lo      <= '0;
              win_len     <= '0;
              running_sum <= '0;
            end
            state <= S_IDLE;
          end
        end
        S_DROP: begin
          state <= (win_lo != tgt_lo) ? S_DROP_ACC : S_ADD;
        end
        S_DROP_ACC: begin
          running_sum <= running_sum - rd_ext;
          win_lo      <= mod_add(win_lo, CFG_W'(1));
          win_len     <= win_len - 1'b1;
          state       <= S_DROP;
        end
        S_ADD: begin
          state <= (win_len != tgt_len) ? S_ADD_ACC : S_DIV;
        end
        S_ADD_ACC: begin
          running_sum <= running_sum + rd_ext;
          win_len     <= win_len + 1'b1;
          state       <= S_ADD;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_valid) begin
            out_valid   <= 1'b1;
            pending     <= pend_dec;
            next_output <= next_output + 1'b1;
            if (left_have != CAP) begin
              left_have <= left_have + 1'b1;
            end
            state <= S_CHECK;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && !out_valid) begin
      average  <= div_q;
      position <= next_output;
      is_last  <= last_flag && (pending == CFG_W'(1));
    end
  end

endmodule

// ===== rtl/core/cwa_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Centered window average: port checker
// Watches the top-level ports over time; bound to the core below.
// ----------------------------------------------------------------------------
`include "centered_window_average_core_assert.svh"

module cwa_checker
  import cwa_pkg::*;
(
  input logic                      clk,
  input logic                      rst,
  input logic                      cfg_valid,
  input logic                      cfg_ready,
  input logic        [CFG_W-1:0]   window_size,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic signed [VALUE_W-1:0] feature_value,
  input logic                      end_of_sequence,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [VALUE_W-1:0] average,
  input logic        [POS_W-1:0]   position,
  input logic                      is_last
);

  `CWA_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(average) && $stable(position) && $stable(is_last),
    "stalled result changed")

  `CWA_ASSERT_NEXT(a_in_busy, in_valid && in_ready, !in_ready,
    "request taken while previous request still in work")

  `CWA_ASSERT_NOW(a_cfg_idle, in_ready, cfg_ready,
    "input open while configuration port closed")

  `CWA_ASSERT_NEXT(a_out_gap, out_valid && out_ready, !out_valid,
    "result presented right after previous one was taken")

endmodule

bind centered_window_average_core cwa_checker u_cwa_checker (.*);
